>>> rtl/core/nfc_df_pkg.sv
package nfc_df_pkg;

    // Frame status codes carried in a status item
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ACK      = 3'd1,
        ST_NACK     = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_BAD_LCS  = 3'd4,
        ST_BAD_DCS  = 3'd5,
        ST_BAD_POST = 3'd6,
        ST_ZERO_LEN = 3'd7
    } frame_status_t;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_LEN  = 7'b0000010,
        PH_LCS  = 7'b0000100,
        PH_TFI  = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_DCS  = 7'b0100000,
        PH_POST = 7'b1000000
    } phase_t;

    localparam logic [7:0] START_BYTE0 = 8'h00;
    localparam logic [7:0] START_BYTE1 = 8'hFF;
    localparam logic [7:0] POSTAMBLE   = 8'h00;

endpackage

>>> rtl/core/nfc_host_frame_deframer_top.sv
// NFC host frame deframer.
// Input channel (in_valid/in_ready) carries one received byte per item in
// rx_byte, or a timeout event when timed_out is 1 (rx_byte then ignored).
// Output channel (out_valid/out_ready) carries data bytes (frame_end = 0)
// and one status item per frame (frame_end = 1, status in frame_status).
// The parser hunts for the 00 FF start code, checks LEN/LCS, drops TFI,
// forwards data bytes, then checks DCS and the postamble.
// Each accepted item updates the parser state in the same cycle and its
// result, if any, sits in the output register on the next cycle. One item
// per cycle is sustained while out_ready holds. The output register is the
// only buffer: a new item is taken while the held result is consumed in
// the same cycle, so a stalled receiver stalls the input with no loss.
// Reset (rst_n low, asynchronous) returns the parser to hunting with an
// empty hunt window and drops any held result.
module nfc_host_frame_deframer_top
    import nfc_df_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       timed_out,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       frame_end,
    output logic [2:0] frame_status
);

    phase_t        phase_reg, phase_next;
    logic [7:0]    prev_byte_reg, prev_byte_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [7:0]    frame_length_reg, frame_length_next;
    logic [7:0]    byte_count_reg, byte_count_next;
    logic [7:0]    running_sum_reg, running_sum_next;
    logic          sum_bad_reg, sum_bad_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    payload_reg, payload_next;
    logic          frame_end_reg, frame_end_next;
    frame_status_t status_reg, status_next;

    logic          accept;
    logic          emit;
    logic          emit_status;
    frame_status_t new_status;
    logic [7:0]    count_inc;
    logic [7:0]    sum_inc;

    // Output register frees up when empty or drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign count_inc = byte_count_reg + 8'd1;
    assign sum_inc   = running_sum_reg + rx_byte;

    // Per-byte parser
    always_comb
    begin
        phase_next        = phase_reg;
        prev_byte_next    = prev_byte_reg;
        prev_valid_next   = prev_valid_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        sum_bad_next      = sum_bad_reg;
        emit              = 1'b0;
        emit_status       = 1'b0;
        new_status        = ST_OK;

        if (timed_out)
        begin
            emit_status = 1'b1;
            new_status  = ST_TIMEOUT;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    frame_length_next = rx_byte;
                    phase_next        = PH_LCS;
                end
                PH_LCS:
                begin
                    if (frame_length_reg == 8'h00 && rx_byte == 8'hFF)
                    begin
                        emit_status = 1'b1;
                        new_status  = ST_ACK;
                    end
                    else if (frame_length_reg == 8'hFF && rx_byte == 8'h00)
                    begin
                        emit_status = 1'b1;
                        new_status  = ST_NACK;
                    end
                    else if (8'(frame_length_reg + rx_byte) != 8'h00)
                    begin
                        emit_status = 1'b1;
                        new_status  = ST_BAD_LCS;
                    end
                    else if (frame_length_reg == 8'h00)
                    begin
                        emit_status = 1'b1;
                        new_status  = ST_ZERO_LEN;
                    end
                    else
                    begin
                        phase_next = PH_TFI;
                    end
                end
                PH_TFI:
                begin
                    running_sum_next = rx_byte;
                    byte_count_next  = 8'd1;
                    sum_bad_next     = 1'b0;
                    phase_next       = (frame_length_reg == 8'd1) ? PH_DCS : PH_DATA;
                end
                PH_DATA:
                begin
                    running_sum_next = sum_inc;
                    byte_count_next  = count_inc;
                    if (count_inc == frame_length_reg)
                    begin
                        phase_next = PH_DCS;
                    end
                    emit = 1'b1;
                end
                PH_DCS:
                begin
                    sum_bad_next = (sum_inc != 8'h00);
                    phase_next   = PH_POST;
                end
                PH_POST:
                begin
                    emit_status = 1'b1;
                    if (sum_bad_reg)
                    begin
                        new_status = ST_BAD_DCS;
                    end
                    else if (rx_byte != POSTAMBLE)
                    begin
                        new_status = ST_BAD_POST;
                    end
                    else
                    begin
                        new_status = ST_OK;
                    end
                end
                default:
                begin
                    // Sliding two-byte window for the start code
                    if (prev_valid_reg && prev_byte_reg == START_BYTE0
                        && rx_byte == START_BYTE1)
                    begin
                        prev_valid_next = 1'b0;
                        prev_byte_next  = 8'h00;
                        phase_next      = PH_LEN;
                    end
                    else
                    begin
                        phase_next      = PH_HUNT;
                        prev_byte_next  = rx_byte;
                        prev_valid_next = 1'b1;
                    end
                end
            endcase
        end

        // Any status item ends the frame and clears the hunt window
        if (emit_status)
        begin
            phase_next      = PH_HUNT;
            prev_valid_next = 1'b0;
            prev_byte_next  = 8'h00;
        end
    end

    // Output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        payload_next   = payload_reg;
        frame_end_next = frame_end_reg;
        status_next    = status_reg;
        if (accept)
        begin
            out_valid_next = emit || emit_status;
            payload_next   = emit_status ? 8'h00 : rx_byte;
            frame_end_next = emit_status;
            status_next    = emit_status ? new_status : ST_OK;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            prev_byte_reg    <= 8'h00;
            prev_valid_reg   <= 1'b0;
            frame_length_reg <= 8'h00;
            byte_count_reg   <= 8'h00;
            running_sum_reg  <= 8'h00;
            sum_bad_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            prev_byte_reg    <= prev_byte_next;
            prev_valid_reg   <= prev_valid_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            sum_bad_reg      <= sum_bad_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg   <= payload_next;
        frame_end_reg <= frame_end_next;
        status_reg    <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign frame_end    = frame_end_reg;
    assign frame_status = status_reg;

endmodule
